[hdl/adpm_pkg.sv]
`timescale 1ns / 1ps

package adpm_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_PATTERN_LEN = 32;
	localparam int DEF_MAX_ERRORS      = 3;
	localparam int DEF_PATTERN_SLOTS   = 4;

	// Fixed field widths
	localparam int SYM_W       = 2;
	localparam int PAT_W       = 64;
	localparam int PAT_SYMS    = PAT_W / SYM_W;
	localparam int LEN_FIELD_W = 6;
	localparam int LENS_W      = 24;
	localparam int LIMIT_W     = 2;
	localparam int MASK_W      = 4;
	localparam int REG_SLOTS   = 4;

	// Register file layout (8-byte stride)
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_A   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_B   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_C   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PATTERN_D   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LENGTHS     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ERROR_LIMIT = 3'd5;

	// Control that travels with each word down the chain
	typedef struct packed {
		logic             vld;
		logic             start;
		logic [SYM_W-1:0] sym;
	} ctl_t;

endpackage

[hdl/approximate_dna_pattern_matcher.sv]
`timescale 1ns / 1ps

// Channel   Handshake                 Word
// -------   -----------------------   ----------------------------------
// in        in_valid / in_ready       symbol_code, start_of_text
// out       out_valid / out_ready     match_mask
// config    APB (psel, penable ...)   six registers at 8-byte stride
//
// One word enters per cycle while the chain advances; each result leaves from the last cell.
// The result passes the row chain: one cell per pattern row, each cell registered.
// Reset clears the stored column, the configuration registers and every stage valid.
// The whole chain holds while the result word at the end waits for out_ready;
// otherwise in_ready stays high.
module approximate_dna_pattern_matcher #(
	parameter int MAX_PATTERN_LEN = adpm_pkg::DEF_MAX_PATTERN_LEN,
	parameter int MAX_ERRORS      = adpm_pkg::DEF_MAX_ERRORS,
	parameter int PATTERN_SLOTS   = adpm_pkg::DEF_PATTERN_SLOTS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [adpm_pkg::SYM_W-1:0]      symbol_code,
	input  logic                            start_of_text,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [adpm_pkg::MASK_W-1:0]     match_mask,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [adpm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [adpm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [adpm_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import adpm_pkg::*;

	localparam int N     = MAX_PATTERN_LEN;
	localparam int LV    = MAX_ERRORS + 1;
	localparam int RW    = (N > 1) ? $clog2(N) : 1;
	localparam int LEN_X = LEN_FIELD_W + 1;

	// Configuration registers
	logic [REG_SLOTS-1:0][PAT_W-1:0] pat_q;
	logic [LENS_W-1:0]               lens_q;
	logic [LIMIT_W-1:0]              limit_q;
	logic [REG_IDX_W-1:0]            reg_idx;
	logic                            wr_en;

	// Per-slot end row of each pattern
	logic [PATTERN_SLOTS-1:0][RW-1:0] last_row;
	logic [PATTERN_SLOTS-1:0]         used;

	// Chain links: entry k feeds cell k
	ctl_t                             ctl   [N+1];
	logic [PATTERN_SLOTS-1:0][LV-1:0] cur   [N+1];
	logic [PATTERN_SLOTS-1:0][LV-1:0] prv   [N+1];
	logic [LV-1:0]                    mask  [N+1];

	logic adv;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1 -: REG_IDX_W];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= '0;
			lens_q  <= '0;
			limit_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PATTERN_A:   pat_q[0] <= pwdata;
				REG_PATTERN_B:   pat_q[1] <= pwdata;
				REG_PATTERN_C:   pat_q[2] <= pwdata;
				REG_PATTERN_D:   pat_q[3] <= pwdata;
				REG_LENGTHS:     lens_q   <= pwdata[LENS_W-1:0];
				REG_ERROR_LIMIT: limit_q  <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN_A:   prdata = pat_q[0];
			REG_PATTERN_B:   prdata = pat_q[1];
			REG_PATTERN_C:   prdata = pat_q[2];
			REG_PATTERN_D:   prdata = pat_q[3];
			REG_LENGTHS:     prdata = APB_DATA_W'(lens_q);
			REG_ERROR_LIMIT: prdata = APB_DATA_W'(limit_q);
			default:         prdata = '0;
		endcase
	end

	// Saturate each length to the chain depth and turn it into the end row
	always_comb begin
		logic [LEN_X-1:0] len;
		for (int s = 0; s < PATTERN_SLOTS; s++) begin
			len     = LEN_X'(lens_q[LEN_FIELD_W*s +: LEN_FIELD_W]);
			used[s] = (len != '0);
			if (len > LEN_X'(N)) begin
				last_row[s] = RW'(N - 1);
			end else begin
				last_row[s] = RW'(len - LEN_X'(1));
			end
		end
	end

	// Advance the chain unless the result word at the end is blocked
	assign adv      = !ctl[N].vld || out_ready;
	assign in_ready = adv;

	assign ctl[0].vld   = in_valid;
	assign ctl[0].start = start_of_text;
	assign ctl[0].sym   = symbol_code;
	assign cur[0]       = '0;
	assign prv[0]       = '0;
	assign mask[0]      = '0;

	for (genvar k = 0; k < N; k++) begin : g_row
		adpm_cell #(
			.ROW          (k),
			.PATTERN_SLOTS(PATTERN_SLOTS),
			.LV           (LV),
			.RW           (RW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.pat     (pat_q),
			.last_row(last_row),
			.used    (used),
			.ctl_in  (ctl[k]),
			.cur_in  (cur[k]),
			.prv_in  (prv[k]),
			.mask_in (mask[k]),
			.ctl_s1  (ctl[k+1]),
			.cur_s1  (cur[k+1]),
			.prv_s1  (prv[k+1]),
			.mask_s1 (mask[k+1])
		);
	end

	assign out_valid = ctl[N].vld;

	// Drop distances above the error limit and above the stored levels
	for (genvar d = 0; d < MASK_W; d++) begin : g_mask
		if (d < LV) begin : g_lvl
			assign match_mask[d] = mask[N][d] && (LIMIT_W'(d) <= limit_q);
		end else begin : g_none
			assign match_mask[d] = 1'b0;
		end
	end

	// The chain only stalls for a waiting result
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A blocked result holds the whole chain
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result blocked");

	// Exact-distance bits above the limit never show
	a_limit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_q == 2'd0 |-> match_mask[3:1] == 3'b000)
		else $error("mask bit above error limit zero");

	a_limit_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && limit_q == 2'd1 |-> match_mask[3:2] == 2'b00)
		else $error("mask bit above error limit one");

endmodule

[hdl/adpm_cell.sv]
`timescale 1ns / 1ps

module adpm_cell #(
	parameter int ROW           = 0,
	parameter int PATTERN_SLOTS = adpm_pkg::DEF_PATTERN_SLOTS,
	parameter int LV            = adpm_pkg::DEF_MAX_ERRORS + 1,
	parameter int RW            = 5
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          adv,
	input  logic [adpm_pkg::REG_SLOTS-1:0][adpm_pkg::PAT_W-1:0] pat,
	input  logic [PATTERN_SLOTS-1:0][RW-1:0]              last_row,
	input  logic [PATTERN_SLOTS-1:0]                      used,
	input  adpm_pkg::ctl_t                                ctl_in,
	input  logic [PATTERN_SLOTS-1:0][LV-1:0]              cur_in,
	input  logic [PATTERN_SLOTS-1:0][LV-1:0]              prv_in,
	input  logic [LV-1:0]                                 mask_in,
	output adpm_pkg::ctl_t                                ctl_s1,
	output logic [PATTERN_SLOTS-1:0][LV-1:0]              cur_s1,
	output logic [PATTERN_SLOTS-1:0][LV-1:0]              prv_s1,
	output logic [LV-1:0]                                 mask_s1
);
	import adpm_pkg::*;

	logic [PATTERN_SLOTS-1:0][LV-1:0] q_q;
	logic [PATTERN_SLOTS-1:0][LV-1:0] cur_nx;
	logic [PATTERN_SLOTS-1:0][LV-1:0] prv_nx;
	logic [PATTERN_SLOTS-1:0][LV-1:0] hit_bits;
	logic [PATTERN_SLOTS-1:0][SYM_W-1:0] psym;
	logic [LV-1:0] mask_nx;

	for (genvar s = 0; s < PATTERN_SLOTS; s++) begin : g_slot
		if (ROW < PAT_SYMS) begin : g_sym
			assign psym[s] = pat[s][SYM_W*ROW +: SYM_W];
		end else begin : g_zero
			assign psym[s] = '0;
		end
	end

	always_comb begin
		logic [LV-1:0] nm;
		logic [LV-1:0] q;
		for (int s = 0; s < PATTERN_SLOTS; s++) begin
			nm = (psym[s] == ctl_in.sym) ? '1 : '0;
			// stored column reads zero on start of text
			q = ctl_in.start ? '0 : q_q[s];
			prv_nx[s] = q;
			if (ROW == 0) begin
				cur_nx[s] = ~LV'(1) | LV'(nm[0]);
			end else begin
				cur_nx[s] = (prv_in[s] & nm)
					| LV'({(prv_in[s] & ~nm) | q | cur_in[s], 1'b0});
			end
			// exact-distance bits of this row, kept only at the end row of a used pattern
			if (used[s] && last_row[s] == RW'(ROW)) begin
				hit_bits[s] = cur_nx[s] & ~LV'({cur_nx[s], 1'b0});
			end else begin
				hit_bits[s] = '0;
			end
		end
	end

	always_comb begin
		mask_nx = mask_in;
		for (int s = 0; s < PATTERN_SLOTS; s++) begin
			mask_nx = mask_nx | hit_bits[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q    <= '0;
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			if (ctl_in.vld) begin
				q_q <= cur_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s1  <= cur_nx;
			prv_s1  <= prv_nx;
			mask_s1 <= mask_nx;
		end
	end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Stream test of the approximate pattern matcher: nucleotide words go in
// through the valid/ready input, match masks come back out, and every mask
// is checked against a bit-parallel edit-distance column kept here.
module testbench;
	import adpm_pkg::*;

	localparam int SLOTS       = DEF_PATTERN_SLOTS;
	localparam int ROWS        = DEF_MAX_PATTERN_LEN;
	localparam int LATENCY     = DEF_MAX_PATTERN_LEN;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD   = 250;
	localparam int PHASES      = 12;

	typedef struct packed {
		logic             start;
		logic [SYM_W-1:0] sym;
	} text_word_t;

	// Every block input starts from a known value
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic [SYM_W-1:0]      symbol_code   = '0;
	logic                  start_of_text = 1'b0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic [MASK_W-1:0]     match_mask;
	logic                  psel          = 1'b0;
	logic                  penable       = 1'b0;
	logic                  pwrite        = 1'b0;
	logic [APB_ADDR_W-1:0] paddr         = '0;
	logic [APB_DATA_W-1:0] pwdata        = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Register shadows and the stored edit-distance column, one entry per slot and row
	logic [PAT_W-1:0]   pattern_shadow [SLOTS];
	logic [LENS_W-1:0]  lengths_shadow;
	logic [LIMIT_W-1:0] limit_shadow;
	logic [MASK_W-1:0]  column_store [SLOTS][ROWS];

	text_word_t        text_words[$];
	logic [MASK_W-1:0] expected_masks[$];

	int words_queued = 0;
	int masks_seen   = 0;
	int fail_count   = 0;
	int hold_at      = -1;
	int cycle_count  = 0;
	int tx_gap       = 0;
	int rx_gap       = 0;
	bit tx_calm      = 1'b0;
	bit rx_calm      = 1'b0;

	approximate_dna_pattern_matcher i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.symbol_code   (symbol_code),
		.start_of_text (start_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_mask    (match_mask),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Advance the stored column by one text symbol and return the mask, within the error
	// limit, of exact error counts at which some used pattern ends here.
	function automatic logic [MASK_W-1:0] next_match_mask(input logic [SYM_W-1:0] sym,
			input logic clear);
		logic [MASK_W-1:0]      cur [ROWS];
		logic [MASK_W-1:0]      hit, prev_diag, prev_same, ends, mask;
		logic [LEN_FIELD_W-1:0] len;
		logic [4:0]             lim_mask;
		int                     s, i;
		mask = '0;
		// Start of text wipes the previous column; row 0 is rebuilt anyway
		if (clear) begin
			for (s = 0; s < SLOTS; s++)
				for (i = 0; i < ROWS; i++)
					column_store[s][i] = '0;
		end
		for (s = 0; s < SLOTS; s++) begin
			len = lengths_shadow[LEN_FIELD_W*s +: LEN_FIELD_W];
			for (i = 0; i < ROWS; i++) begin
				hit = (pattern_shadow[s][SYM_W*i +: SYM_W] == sym) ? '1 : '0;
				if (i == 0) begin
					cur[0] = 4'b1110 | (hit & 4'b0001);
				end else begin
					// Match keeps the level; substitution, insertion and deletion
					// each cost one level
					prev_diag = column_store[s][i-1];
					prev_same = column_store[s][i];
					cur[i] = (prev_diag & hit) | (((prev_diag & ~hit) | prev_same | cur[i-1]) << 1);
				end
			end
			// Unused slot contributes nothing; overlong lengths clamp to the last row
			if (len != 0) begin
				if (len > ROWS)
					len = LEN_FIELD_W'(ROWS);
				ends = cur[len-1];
				mask = mask | (ends & ~(ends << 1));
			end
			for (i = 0; i < ROWS; i++)
				column_store[s][i] = cur[i];
		end
		lim_mask = (5'd2 << limit_shadow) - 5'd1;
		return mask & lim_mask[MASK_W-1:0];
	endfunction

	function automatic void push_word(input logic [SYM_W-1:0] sym, input logic start);
		text_words.push_back({start, sym});
		words_queued++;
	endfunction

	// Register write with setup and access phases; update the shadow once the access edge has passed
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C, REG_PATTERN_D: pattern_shadow[idx] = val;
			REG_LENGTHS: lengths_shadow = val[LENS_W-1:0];
			REG_ERROR_LIMIT: limit_shadow = val[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_patterns(input logic [PAT_W-1:0] pa, input logic [PAT_W-1:0] pb,
			input logic [PAT_W-1:0] pc, input logic [PAT_W-1:0] pd,
			input logic [LENS_W-1:0] lens, input logic [LIMIT_W-1:0] lim);
		reg_write(REG_PATTERN_A, pa);
		reg_write(REG_PATTERN_B, pb);
		reg_write(REG_PATTERN_C, pc);
		reg_write(REG_PATTERN_D, pd);
		reg_write(REG_LENGTHS, {40'd0, lens});
		reg_write(REG_ERROR_LIMIT, {62'd0, lim});
	endtask

	// Hold until every queued word has come back as a mask
	task automatic wait_drained();
		do @(posedge clk);
		while (masks_seen != words_queued);
	endtask

	// Sender: present one word at a time, with a drawn gap after each
	always @(posedge clk or negedge arst_n) begin : drive_text
		text_word_t word;
		if (!arst_n) begin
			in_valid      <= 1'b0;
			symbol_code   <= '0;
			start_of_text <= 1'b0;
			tx_gap        <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_masks.push_back(next_match_mask(symbol_code, start_of_text));
			if (!in_valid || in_ready) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap   <= tx_gap - 1;
				end else if (text_words.size() != 0) begin
					word           = text_words.pop_front();
					in_valid      <= 1'b1;
					symbol_code   <= word.sym;
					start_of_text <= word.start;
					tx_gap        <= tx_calm ? 0 : $urandom_range(0, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each mask, then drop ready for a drawn hold-off unless the draw is zero
	always @(posedge clk or negedge arst_n) begin : check_masks
		logic [MASK_W-1:0] want;
		int unsigned       stall;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			rx_gap     <= 0;
			masks_seen <= 0;
		end else if (out_valid && out_ready) begin
			if (expected_masks.size() == 0) begin
				$error("match_mask: no word pending, actual %h", match_mask);
				fail_count++;
			end else begin
				want = expected_masks.pop_front();
				if (match_mask !== want) begin
					$error("match_mask: expected %h, actual %h", want, match_mask);
					fail_count++;
				end
			end
			masks_seen <= masks_seen + 1;
			stall = rx_calm ? 0 : $urandom_range(0, 15);
			// One long hold-off so the chain fills and in_ready drops
			if (masks_seen + 1 == hold_at)
				stall = LONG_HOLD;
			if (stall == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				rx_gap    <= stall;
			end
		end else if (!out_ready) begin
			if (rx_gap <= 1) begin
				out_ready <= 1'b1;
				rx_gap    <= 0;
			end else begin
				rx_gap <= rx_gap - 1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : run_phases
		logic [PAT_W-1:0]       pat [SLOTS];
		logic [LEN_FIELD_W-1:0] lens [SLOTS];
		logic [LIMIT_W-1:0]     lim;
		int                     phase, target, base, s, k, span, off, pick, burst;
		for (s = 0; s < SLOTS; s++) begin
			pattern_shadow[s] = '0;
			for (k = 0; k < ROWS; k++)
				column_store[s][k] = '0;
		end
		lengths_shadow = '0;
		limit_shadow   = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: no slot in use, so every mask is zero
		for (k = 0; k < 8; k++)
			push_word(SYM_W'($urandom_range(0, 3)), k == 0);
		wait_drained();

		// Directed: one-symbol slot, a short ACGT-style slot, a saturating
		// length on an all-zero pattern, an unused slot, full error limit
		load_patterns(64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_0000_00E4, 64'h0,
			{$urandom, $urandom}, {6'd0, 6'd63, 6'd4, 6'd1}, 2'd3);
		push_word(2, 1);
		// exact, substituted, deleted and inserted copies of slot b
		push_word(0, 0); push_word(1, 0); push_word(2, 0); push_word(3, 0);
		push_word(0, 0); push_word(1, 0); push_word(3, 0); push_word(3, 0);
		push_word(0, 0); push_word(2, 0); push_word(3, 0);
		push_word(0, 0); push_word(1, 0); push_word(1, 0); push_word(2, 0); push_word(3, 0);
		// restart in the middle of the stream
		push_word(0, 1); push_word(1, 0); push_word(2, 0); push_word(3, 0);
		push_word(0, 0); push_word(0, 0);
		wait_drained();

		for (phase = 0; phase < PHASES; phase++) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			target  = 60;
			for (s = 0; s < SLOTS; s++) begin
				pick   = $urandom_range(0, 9);
				pat[s] = {$urandom, $urandom};
				if (pick == 0)
					pat[s] = '0;
				else if (pick == 1)
					pat[s] = '1;
				pick = $urandom_range(0, 9);
				if (pick == 0)
					lens[s] = '0;
				else if (pick <= 6)
					lens[s] = LEN_FIELD_W'($urandom_range(1, 8));
				else if (pick == 7)
					lens[s] = LEN_FIELD_W'($urandom_range(9, 31));
				else if (pick == 8)
					lens[s] = LEN_FIELD_W'(ROWS);
				else
					lens[s] = LEN_FIELD_W'($urandom_range(33, 63));
			end
			lim = LIMIT_W'($urandom_range(0, 3));
			case (phase)
				0: begin
					for (s = 0; s < SLOTS; s++)
						lens[s] = LEN_FIELD_W'(ROWS);
					lim = 2'd3;
				end
				1: begin
					for (s = 0; s < SLOTS; s++) begin
						pat[s]  = '1;
						lens[s] = '1;
					end
					lim = 2'd0;
				end
				2: begin
					for (s = 0; s < SLOTS; s++)
						lens[s] = '0;
				end
				4: begin
					// Keep the sender busy while the receiver holds off
					tx_calm = 1'b1;
					target  = 150;
					hold_at = masks_seen + 5;
				end
				default: ;
			endcase
			load_patterns(pat[0], pat[1], pat[2], pat[3], {lens[3], lens[2], lens[1], lens[0]}, lim);

			// Mostly mutated copies of the configured patterns, some noise and restarts
			base = words_queued;
			while (words_queued - base < target) begin
				pick = $urandom_range(0, 9);
				if (pick <= 6) begin
					s    = $urandom_range(0, SLOTS - 1);
					span = (lens[s] == 0) ? 8 : (lens[s] > ROWS) ? ROWS : int'(lens[s]);
					off  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : 0;
					for (k = off; k < span; k++) begin
						pick = $urandom_range(0, 15);
						// drop the symbol on a deletion, add a stray one on an insertion
						if (pick != 1) begin
							if (pick == 2)
								push_word(SYM_W'($urandom_range(0, 3)), 1'b0);
							push_word((pick == 0) ? SYM_W'($urandom_range(0, 3))
								: pat[s][SYM_W*k +: SYM_W], 1'b0);
						end
					end
				end else if (pick <= 8) begin
					burst = $urandom_range(1, 6);
					for (k = 0; k < burst; k++)
						push_word(SYM_W'($urandom_range(0, 3)), 1'b0);
				end else begin
					push_word(SYM_W'($urandom_range(0, 3)), 1'b1);
				end
			end
			wait_drained();
		end

		repeat (2 * LATENCY + 8) @(posedge clk);
		if (fail_count == 0 && expected_masks.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
